/* rtl/core/wlcc_pkg.sv */
package wlcc_pkg;

    // Raw pixel bits that are used; this is the full width of raw_pixel.
    localparam int PIXEL_BITS = 16;

    localparam int RAW_W   = 16;
    localparam int WIN_W   = 16;
    localparam int SHIFT_W = 4;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CHAN_W  = 8;

    // Saturation threshold on the shifted value.
    localparam int SAT_W = 12;
    localparam logic [SAT_W-1:0] SAT_LEVEL = 12'd4095;

    // Upper bound may be window_low + 1, so it needs one extra bit.
    localparam int HI_W  = WIN_W + 1;
    // (v - low) * 255 with v - low < 4096.
    localparam int NUM_W = SAT_W + CHAN_W;
    // Restoring divider, one quotient bit per stage.
    localparam int DIV_STEPS = CHAN_W;
    localparam int CMP_W = HI_W + DIV_STEPS;

    // Accept edge to the edge at which the result word is taken.
    localparam int LATENCY = DIV_STEPS + 4;

    localparam logic [CHAN_W-1:0] FULL = 8'd255;
    localparam logic [CHAN_W-1:0] NONE = 8'd0;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_CODE  = 2'd3;

    typedef enum logic [1:0] {
        CLS_SAT   = 2'd0,
        CLS_OVER  = 2'd1,
        CLS_UNDER = 2'd2,
        CLS_GREY  = 2'd3
    } pix_class_t;

endpackage

/* rtl/core/window_level_color_coder_top.sv */
// Window/level color coder. One 16-bit camera pixel goes in with start
// whenever busy is low; busy never rises, so a pixel may be given in every
// clock cycle. Each pixel gives one RGB888 word on red/green/blue, marked by
// done for exactly one cycle; words come out in input order. The pipeline
// is shift, classify, scale by 255, eight one-bit restoring divide stages
// and the color select, each a register stage. The receiver cannot stall,
// so there is no backpressure: a word that is not taken while done is high
// is gone. Configuration (window_low, window_high, shift_amount, color_code)
// is written through cfg_write/cfg_index/cfg_data and must only change
// while no pixel is in flight; registers reset to low 0, high 4095,
// shift 0, color coding off.
module window_level_color_coder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [wlcc_pkg::RAW_W-1:0]          raw_pixel,
    input  logic                                cfg_write,
    input  logic [wlcc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wlcc_pkg::CFG_W-1:0]          cfg_data,
    output logic                                done,
    output logic [wlcc_pkg::CHAN_W-1:0]         red,
    output logic [wlcc_pkg::CHAN_W-1:0]         green,
    output logic [wlcc_pkg::CHAN_W-1:0]         blue
);

    localparam int PB    = wlcc_pkg::PIXEL_BITS;
    localparam int STEPS = wlcc_pkg::DIV_STEPS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [wlcc_pkg::WIN_W-1:0]   window_low_reg;
    logic [wlcc_pkg::WIN_W-1:0]   window_high_reg;
    logic [wlcc_pkg::SHIFT_W-1:0] shift_amount_reg;
    logic                         color_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_low_reg   <= '0;
            window_high_reg  <= wlcc_pkg::WIN_W'(4095);
            shift_amount_reg <= '0;
            color_code_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wlcc_pkg::REG_WINDOW_LOW:  window_low_reg   <= cfg_data[wlcc_pkg::WIN_W-1:0];
                wlcc_pkg::REG_WINDOW_HIGH: window_high_reg  <= cfg_data[wlcc_pkg::WIN_W-1:0];
                wlcc_pkg::REG_SHIFT:       shift_amount_reg <= cfg_data[wlcc_pkg::SHIFT_W-1:0];
                wlcc_pkg::REG_COLOR_CODE:  color_code_reg   <= cfg_data[0];
                default:                   color_code_reg   <= color_code_reg;
            endcase
        end
    end

    // Effective upper bound: low + 1 when the window is empty.
    logic [wlcc_pkg::HI_W-1:0] hi_eff;
    logic [wlcc_pkg::HI_W-1:0] lo_ext;

    always_comb
    begin
        lo_ext = {1'b0, window_low_reg};
        if (window_high_reg <= window_low_reg)
            hi_eff = lo_ext + wlcc_pkg::HI_W'(1);
        else
            hi_eff = {1'b0, window_high_reg};
    end

    // No backpressure anywhere: a word can enter every cycle.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: mask and shift
    // ------------------------------------------------------------------
    logic          s1_valid_reg;
    logic [PB-1:0] s1_value_reg;
    logic [PB-1:0] s1_value_next;

    assign s1_value_next = raw_pixel[PB-1:0] >> shift_amount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_value_reg <= s1_value_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: classify; saturation test comes first
    // ------------------------------------------------------------------
    logic                         s2_valid_reg;
    wlcc_pkg::pix_class_t         s2_class_reg;
    wlcc_pkg::pix_class_t         s2_class_next;
    logic [wlcc_pkg::SAT_W-1:0]   s2_diff_reg;
    logic [wlcc_pkg::SAT_W-1:0]   s2_diff_next;
    logic [wlcc_pkg::HI_W-1:0]    s2_div_reg;
    logic [wlcc_pkg::HI_W-1:0]    s2_div_next;
    logic [wlcc_pkg::HI_W-1:0]    s1_value_ext;
    logic [wlcc_pkg::HI_W-1:0]    diff_full;

    always_comb
    begin
        s1_value_ext = wlcc_pkg::HI_W'(s1_value_reg);
        diff_full    = s1_value_ext - lo_ext;
        // Inside the window v < 4095, so the difference fits 12 bits.
        s2_diff_next = diff_full[wlcc_pkg::SAT_W-1:0];
        s2_div_next  = hi_eff - lo_ext;
        priority if (s1_value_ext >= wlcc_pkg::HI_W'(wlcc_pkg::SAT_LEVEL))
            s2_class_next = wlcc_pkg::CLS_SAT;
        else if (s1_value_ext > hi_eff)
            s2_class_next = wlcc_pkg::CLS_OVER;
        else if (s1_value_ext < lo_ext)
            s2_class_next = wlcc_pkg::CLS_UNDER;
        else
            s2_class_next = wlcc_pkg::CLS_GREY;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_class_reg <= s2_class_next;
        s2_diff_reg  <= s2_diff_next;
        s2_div_reg   <= s2_div_next;
    end

    // ------------------------------------------------------------------
    // Stage 3 (divider slot 0): numerator = diff * 255 = diff*256 - diff
    // Slots 1..8: one restoring divide step each, MSB first.
    // ------------------------------------------------------------------
    logic                         dv_valid_reg [0:STEPS];
    wlcc_pkg::pix_class_t         dv_class_reg [0:STEPS];
    logic [wlcc_pkg::NUM_W-1:0]   dv_rem_reg   [0:STEPS];
    logic [wlcc_pkg::HI_W-1:0]    dv_div_reg   [0:STEPS];
    logic [STEPS-1:0]             dv_quo_reg   [0:STEPS];
    logic [wlcc_pkg::NUM_W-1:0]   num_next;

    assign num_next = {s2_diff_reg, wlcc_pkg::CHAN_W'(0)}
                    - wlcc_pkg::NUM_W'(s2_diff_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else
            dv_valid_reg[0] <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        dv_class_reg[0] <= s2_class_reg;
        dv_rem_reg[0]   <= num_next;
        dv_div_reg[0]   <= s2_div_reg;
        dv_quo_reg[0]   <= '0;
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_div
        // Divisor aligned to quotient bit STEPS-1-k.
        logic [wlcc_pkg::CMP_W-1:0] div_sh;
        logic [wlcc_pkg::CMP_W-1:0] rem_ext;
        logic [wlcc_pkg::CMP_W-1:0] trial;
        logic                       take;
        logic [wlcc_pkg::NUM_W-1:0] rem_next;
        logic [STEPS-1:0]           quo_next;

        always_comb
        begin
            div_sh   = wlcc_pkg::CMP_W'(dv_div_reg[k]) << (STEPS - 1 - k);
            rem_ext  = wlcc_pkg::CMP_W'(dv_rem_reg[k]);
            trial    = rem_ext - div_sh;
            take     = rem_ext >= div_sh;
            rem_next = take ? trial[wlcc_pkg::NUM_W-1:0] : dv_rem_reg[k];
            quo_next = dv_quo_reg[k];
            quo_next[STEPS-1-k] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            dv_class_reg[k+1] <= dv_class_reg[k];
            dv_rem_reg[k+1]   <= rem_next;
            dv_div_reg[k+1]   <= dv_div_reg[k];
            dv_quo_reg[k+1]   <= quo_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: color select
    // ------------------------------------------------------------------
    logic                        done_reg;
    logic [wlcc_pkg::CHAN_W-1:0] red_reg,   red_next;
    logic [wlcc_pkg::CHAN_W-1:0] green_reg, green_next;
    logic [wlcc_pkg::CHAN_W-1:0] blue_reg,  blue_next;

    always_comb
    begin
        unique case (dv_class_reg[STEPS])
            wlcc_pkg::CLS_SAT:
            begin
                red_next   = wlcc_pkg::FULL;
                green_next = color_code_reg ? wlcc_pkg::NONE : wlcc_pkg::FULL;
                blue_next  = color_code_reg ? wlcc_pkg::NONE : wlcc_pkg::FULL;
            end
            wlcc_pkg::CLS_OVER:
            begin
                red_next   = color_code_reg ? wlcc_pkg::NONE : wlcc_pkg::FULL;
                green_next = color_code_reg ? wlcc_pkg::NONE : wlcc_pkg::FULL;
                blue_next  = wlcc_pkg::FULL;
            end
            wlcc_pkg::CLS_UNDER:
            begin
                red_next   = wlcc_pkg::NONE;
                green_next = color_code_reg ? wlcc_pkg::FULL : wlcc_pkg::NONE;
                blue_next  = wlcc_pkg::NONE;
            end
            default:
            begin
                red_next   = dv_quo_reg[STEPS];
                green_next = dv_quo_reg[STEPS];
                blue_next  = dv_quo_reg[STEPS];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every accepted pixel yields a word after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(wlcc_pkg::LATENCY) done)
        else $error("accepted pixel produced no word");

    // No word without an accepted pixel.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, wlcc_pkg::LATENCY))
        else $error("word without accepted pixel");

    // In-window division finishes with remainder below the divisor.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid_reg[STEPS] && dv_class_reg[STEPS] == wlcc_pkg::CLS_GREY)
        |-> (wlcc_pkg::HI_W'(dv_rem_reg[STEPS]) < dv_div_reg[STEPS]))
        else $error("divider remainder not below divisor");

    // Without color coding every word is a grey level.
    a_grey_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !color_code_reg) |-> (red == green && green == blue))
        else $error("color in a grey-only word");

endmodule
